/* rtl/servo_angle_speed_controller_top_macros.svh */
// ============================================================================
// Assertion macros for the servo angle and speed controller
// Short forms for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef SERVO_ANGLE_SPEED_CONTROLLER_TOP_MACROS_SVH
`define SERVO_ANGLE_SPEED_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SASC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sasc_pkg.sv */
// ============================================================================
// sasc_pkg
// Shared types and constants of the servo angle and speed controller.
// ============================================================================
`default_nettype none

package sasc_pkg;

    // Number of pipeline stages ahead of the output register, counting the
    // input register as stage 1.
    localparam int NUM_STAGES = 7;

    typedef enum logic [2:0] {
        CFG_STOP_BAND         = 3'd0,
        CFG_SLOW_BAND         = 3'd1,
        CFG_SLOW_SPEED        = 3'd2,
        CFG_MAX_SPEED         = 3'd3,
        CFG_GAIN_TENTHS       = 3'd4,
        CFG_PULSE_OFFSET      = 3'd5,
        CFG_DRIVE_CENTER      = 3'd6,
        CFG_REVERSE_DIRECTION = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] stop_band;
        logic [7:0] slow_band;
        logic [6:0] slow_speed;
        logic [6:0] max_speed;
        logic [7:0] gain_tenths;
        logic [7:0] pulse_offset;
        logic [7:0] drive_center;
        logic       reverse_direction;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stop_band:         8'd3,
        slow_band:         8'd8,
        slow_speed:        7'd30,
        max_speed:         7'd90,
        gain_tenths:       8'd27,
        pulse_offset:      8'd30,
        drive_center:      8'd90,
        reverse_direction: 1'b0
    };

    // Load strobes for every pipeline stage and for the output register.
    typedef struct packed {
        logic [NUM_STAGES:1] stage_load;
        logic                out_load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [7:0]        drive;
        logic signed [7:0] sspeed;
        logic              at_rest;
        logic [10:0]       position;
    } result_t;

    localparam logic [14:0] SUM_MAX     = 15'd32767;
    localparam logic [10:0] POS_MAX     = 11'd2047;
    localparam logic [12:0] SPEED_LIMIT = 13'd90;
    localparam logic [7:0]  DRIVE_LIMIT = 8'd180;
    localparam logic [8:0]  FULL_TURN   = 9'd360;
    localparam logic [8:0]  HALF_TURN   = 9'd180;

    // Position scale 342/1000: multiply by 342, then divide by 1000 through
    // a reciprocal that is exact for every product below 2^24.
    localparam logic [8:0]  POS_SCALE   = 9'd342;
    localparam logic [24:0] RECIP_1000  = 25'd17179870;
    localparam int          SHIFT_1000  = 34;

    // Divide by 10 through a reciprocal that is exact for 16-bit values.
    localparam logic [16:0] RECIP_10    = 17'd104858;
    localparam int          SHIFT_10    = 20;

endpackage

`default_nettype wire

/* rtl/servo_angle_speed_controller_top.sv */
// ============================================================================
// servo_angle_speed_controller_top: proportional servo position control
// A request passes through the pipeline stages and the output register to the result.
// Throughput: one request per cycle while in_stall is low; the pulse accumulator updates once per request.
// Reset clears the accumulator, sample count and position, empties the
// pipeline and loads every configuration register with its default.
// ============================================================================
`default_nettype none

`include "servo_angle_speed_controller_top_macros.svh"

module servo_angle_speed_controller_top #(
    parameter int SAMPLES_PER_AVERAGE = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Configuration write port
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,

    // Request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [11:0]        pulse_width,
    input  wire logic [8:0]         target_angle,

    // Result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              drive_value,
    output logic signed [7:0]       signed_speed,
    output logic                    at_rest,
    output logic [10:0]             position_deg
);

    // ------------------------------------------------------------------------
    // The datapath is a seven-stage pipeline followed by an output register.
    // Stage 1 is the input register. Leaving stage 1, the pulse sample is
    // added into the accumulator; the accumulator is read and written in that
    // same move, so a request can enter on every clock while nothing stalls.
    // Stages 3 to 5 form the averaged position (divide by the sample count,
    // scale by 342/1000) with one multiplier per stage. When an averaging
    // request moves into stage 6, the position registers are updated; every
    // request behind it sees the new position, every request ahead of it has
    // already used the old one. Stages 6 and 7 form the error and the speed.
    //
    // Each stage advances when the next one is empty or advancing itself, so
    // bubbles close up and the block keeps taking requests while a finished
    // result waits in the output register.
    // ------------------------------------------------------------------------

    localparam int NS = sasc_pkg::NUM_STAGES;

    sasc_pkg::cfg_t       cfg_reg;
    sasc_pkg::pipe_ctrl_t ctrl;
    sasc_pkg::result_t    result;

    logic [NS:1]   stage_valid_reg, stage_valid_next;
    logic [NS:1]   stage_move;
    logic [NS+1:1] stage_ready;
    logic          accept;
    logic          out_valid_reg, out_valid_next;
    sasc_pkg::result_t out_data_reg;

    logic [8:0]  tgt_mod;
    logic [10:0] item_position;
    logic [8:0]  pos_mod;

    // Configuration registers. Every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sasc_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (sasc_pkg::cfg_index_t'(cfg_index))
                sasc_pkg::CFG_STOP_BAND:         cfg_reg.stop_band         <= cfg_data;
                sasc_pkg::CFG_SLOW_BAND:         cfg_reg.slow_band         <= cfg_data;
                sasc_pkg::CFG_SLOW_SPEED:        cfg_reg.slow_speed        <= cfg_data[6:0];
                sasc_pkg::CFG_MAX_SPEED:         cfg_reg.max_speed         <= cfg_data[6:0];
                sasc_pkg::CFG_GAIN_TENTHS:       cfg_reg.gain_tenths       <= cfg_data;
                sasc_pkg::CFG_PULSE_OFFSET:      cfg_reg.pulse_offset      <= cfg_data;
                sasc_pkg::CFG_DRIVE_CENTER:      cfg_reg.drive_center      <= cfg_data;
                sasc_pkg::CFG_REVERSE_DIRECTION: cfg_reg.reverse_direction <= cfg_data[0];
                default:                         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Pipeline flow control. The output register is free when it is empty or
    // its result is being taken; readiness then ripples back stage by stage.
    always_comb
    begin
        stage_ready[NS + 1] = !out_valid_reg || !out_stall;
        for (int k = NS; k >= 1; k--)
        begin
            stage_move[k]  = stage_valid_reg[k] && stage_ready[k + 1];
            stage_ready[k] = !stage_valid_reg[k] || stage_move[k];
        end
        accept = in_valid && stage_ready[1];

        stage_valid_next[1] = accept || (stage_valid_reg[1] && !stage_move[1]);
        ctrl.stage_load[1]  = accept;
        for (int k = 2; k <= NS; k++)
        begin
            stage_valid_next[k] = stage_move[k - 1] || (stage_valid_reg[k] && !stage_move[k]);
            ctrl.stage_load[k]  = stage_move[k - 1];
        end
        ctrl.out_load  = stage_move[NS];
        out_valid_next = stage_move[NS] || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    sasc_position #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_position (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .pulse_width   (pulse_width),
        .target_angle  (target_angle),
        .tgt_mod       (tgt_mod),
        .item_position (item_position),
        .pos_mod       (pos_mod)
    );

    sasc_speed u_speed (
        .clk           (clk),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .tgt_mod       (tgt_mod),
        .item_position (item_position),
        .pos_mod       (pos_mod),
        .result        (result)
    );

    // Output register: holds a result steady while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            out_data_reg <= result;
    end

    assign in_stall     = !stage_ready[1];
    assign out_valid    = out_valid_reg;
    assign drive_value  = out_data_reg.drive;
    assign signed_speed = out_data_reg.sspeed;
    assign at_rest      = out_data_reg.at_rest;
    assign position_deg = out_data_reg.position;

    // A shown result reports rest exactly when its signed speed is zero.
    `SASC_ASSERT_SAME(a_rest_matches_speed, out_valid_reg, at_rest == (signed_speed == 8'sd0), "at_rest disagrees with signed_speed")

    // The drive command never leaves the servo's range.
    `SASC_ASSERT_SAME(a_drive_in_range, out_valid_reg, drive_value <= sasc_pkg::DRIVE_LIMIT, "drive_value above its limit")

    // A request held in the input stage is never dropped.
    `SASC_ASSERT_NEXT(a_stage1_holds, stage_valid_reg[1] && !stage_move[1], stage_valid_reg[1], "request lost from the input stage")

endmodule

`default_nettype wire

/* rtl/sasc_position.sv */
// ============================================================================
// sasc_position
// Input register, pulse accumulator and the pipelined position estimate.
// ============================================================================
`default_nettype none

module sasc_position #(
    parameter int SAMPLES_PER_AVERAGE = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sasc_pkg::pipe_ctrl_t ctrl,
    input  wire sasc_pkg::cfg_t      cfg,
    input  wire logic [11:0]         pulse_width,
    input  wire logic [8:0]          target_angle,
    output logic [8:0]               tgt_mod,
    output logic [10:0]              item_position,
    output logic [8:0]               pos_mod
);

    localparam logic [3:0]  AVG_COUNT = 4'(SAMPLES_PER_AVERAGE);
    localparam int          SHIFT_N   = 19;
    localparam logic [19:0] RECIP_N   =
        20'((2 ** SHIFT_N + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    function automatic logic [8:0] wrap_turn(input logic [10:0] deg);
        logic [10:0] r;
        begin
            if (deg >= 11'd1800)
                r = deg - 11'd1800;
            else if (deg >= 11'd1440)
                r = deg - 11'd1440;
            else if (deg >= 11'd1080)
                r = deg - 11'd1080;
            else if (deg >= 11'd720)
                r = deg - 11'd720;
            else if (deg >= 11'd360)
                r = deg - 11'd360;
            else
                r = deg;
            return r[8:0];
        end
    endfunction

    // State
    logic [14:0] pulse_sum_reg, pulse_sum_next;
    logic [3:0]  sample_count_reg, sample_count_next;
    logic [10:0] averaged_position_reg;
    logic [8:0]  pos_mod_reg;

    // Stage payloads
    logic [11:0] pw1_reg;
    logic [8:0]  tgt1_reg;
    logic [8:0]  tmod2_reg, tmod3_reg, tmod4_reg, tmod5_reg;
    logic        avg2_reg, avg3_reg, avg4_reg, avg5_reg;
    logic [14:0] sum2_reg;
    logic [14:0] q3_reg;
    logic [23:0] y4_reg;
    logic [10:0] p5_reg;

    logic [11:0] sample;
    logic [15:0] sum_wide;
    logic [14:0] sum_sat;
    logic [3:0]  count_inc;
    logic        avg_now;
    logic [8:0]  tmod_in;
    logic [34:0] prod3;
    logic [23:0] prod4;
    logic [48:0] prod5;
    logic [13:0] p_wide;
    logic [10:0] p_sat;

    always_comb
    begin
        sample    = (pw1_reg > {4'd0, cfg.pulse_offset}) ?
                    pw1_reg - {4'd0, cfg.pulse_offset} : 12'd0;
        sum_wide  = {1'b0, pulse_sum_reg} + {4'd0, sample};
        sum_sat   = (sum_wide > {1'b0, sasc_pkg::SUM_MAX}) ? sasc_pkg::SUM_MAX
                                                           : sum_wide[14:0];
        count_inc = sample_count_reg + 4'd1;
        avg_now   = (count_inc >= AVG_COUNT);
        tmod_in   = (tgt1_reg >= sasc_pkg::FULL_TURN) ? tgt1_reg - sasc_pkg::FULL_TURN
                                                      : tgt1_reg;
        pulse_sum_next    = avg_now ? 15'd0 : sum_sat;
        sample_count_next = avg_now ? 4'd0 : count_inc;
    end

    assign prod3  = 35'(sum2_reg) * 35'(RECIP_N);
    assign prod4  = 24'(q3_reg) * 24'(sasc_pkg::POS_SCALE);
    assign prod5  = 49'(y4_reg) * 49'(sasc_pkg::RECIP_1000);
    assign p_wide = prod5[sasc_pkg::SHIFT_1000 +: 14];
    assign p_sat  = (p_wide > {3'd0, sasc_pkg::POS_MAX}) ? sasc_pkg::POS_MAX
                                                         : p_wide[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_sum_reg         <= '0;
            sample_count_reg      <= '0;
            averaged_position_reg <= '0;
            pos_mod_reg           <= '0;
        end
        else
        begin
            if (ctrl.stage_load[2])
            begin
                pulse_sum_reg    <= pulse_sum_next;
                sample_count_reg <= sample_count_next;
            end
            if (ctrl.stage_load[6] && avg5_reg)
            begin
                averaged_position_reg <= p5_reg;
                pos_mod_reg           <= wrap_turn(p5_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[1])
        begin
            pw1_reg  <= pulse_width;
            tgt1_reg <= target_angle;
        end
        if (ctrl.stage_load[2])
        begin
            tmod2_reg <= tmod_in;
            avg2_reg  <= avg_now;
            sum2_reg  <= sum_sat;
        end
        if (ctrl.stage_load[3])
        begin
            tmod3_reg <= tmod2_reg;
            avg3_reg  <= avg2_reg;
            q3_reg    <= prod3[SHIFT_N +: 15];
        end
        if (ctrl.stage_load[4])
        begin
            tmod4_reg <= tmod3_reg;
            avg4_reg  <= avg3_reg;
            y4_reg    <= prod4;
        end
        if (ctrl.stage_load[5])
        begin
            tmod5_reg <= tmod4_reg;
            avg5_reg  <= avg4_reg;
            p5_reg    <= p_sat;
        end
    end

    assign tgt_mod       = tmod5_reg;
    assign item_position = avg5_reg ? p5_reg : averaged_position_reg;
    assign pos_mod       = pos_mod_reg;

endmodule

`default_nettype wire

/* rtl/sasc_speed.sv */
// ============================================================================
// sasc_speed
// Wrapped angle error, dead band selection, speed clamp and drive value.
// ============================================================================
`default_nettype none

module sasc_speed (
    input  wire logic                 clk,
    input  wire sasc_pkg::pipe_ctrl_t ctrl,
    input  wire sasc_pkg::cfg_t       cfg,
    input  wire logic [8:0]           tgt_mod,
    input  wire logic [10:0]          item_position,
    input  wire logic [8:0]           pos_mod,
    output sasc_pkg::result_t         result
);

    logic [8:0]  tgt6_reg;
    logic [10:0] pos6_reg;
    logic [7:0]  mag7_reg;
    logic        neg7_reg;
    logic [15:0] prod7_reg;
    logic [10:0] pos7_reg;

    logic signed [10:0] diff;
    logic signed [10:0] wrapped;
    logic signed [10:0] err;
    logic [10:0]        mag_wide;
    logic [7:0]         mag;
    logic [15:0]        prod6;

    logic [32:0]        scaled_prod;
    logic [12:0]        scaled;
    logic [12:0]        speed_wide;
    logic [6:0]         speed;
    logic               forward;
    logic signed [7:0]  sspeed;
    logic signed [9:0]  drive_wide;
    logic [7:0]         drive;

    // Error in [-180, 179] from the target and position, both already reduced mod 360.
    always_comb
    begin
        diff = $signed({2'b00, tgt6_reg}) - $signed({2'b00, pos_mod})
             + $signed({2'b00, sasc_pkg::HALF_TURN});
        if (diff < 0)
            wrapped = diff + $signed({2'b00, sasc_pkg::FULL_TURN});
        else if (diff >= $signed({2'b00, sasc_pkg::FULL_TURN}))
            wrapped = diff - $signed({2'b00, sasc_pkg::FULL_TURN});
        else
            wrapped = diff;
        err      = wrapped - $signed({2'b00, sasc_pkg::HALF_TURN});
        mag_wide = (err < 0) ? 11'(-err) : 11'(err);
        mag      = mag_wide[7:0];
        prod6    = {8'd0, mag} * {8'd0, cfg.gain_tenths};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[6])
        begin
            tgt6_reg <= tgt_mod;
            pos6_reg <= item_position;
        end
        if (ctrl.stage_load[7])
        begin
            mag7_reg  <= mag;
            neg7_reg  <= err[10];
            prod7_reg <= prod6;
            pos7_reg  <= pos6_reg;
        end
    end

    assign scaled_prod = 33'(prod7_reg) * 33'(sasc_pkg::RECIP_10);
    assign scaled      = scaled_prod[sasc_pkg::SHIFT_10 +: 13];

    always_comb
    begin
        if (mag7_reg < cfg.stop_band)
        begin
            speed_wide = 13'd0;
        end
        else
        begin
            if (mag7_reg < cfg.slow_band)
            begin
                speed_wide = {6'd0, cfg.slow_speed};
            end
            else
            begin
                speed_wide = scaled;
                if (speed_wide < {6'd0, cfg.slow_speed})
                    speed_wide = {6'd0, cfg.slow_speed};
            end
            if (speed_wide > {6'd0, cfg.max_speed})
                speed_wide = {6'd0, cfg.max_speed};
        end
        if (speed_wide > sasc_pkg::SPEED_LIMIT)
            speed_wide = sasc_pkg::SPEED_LIMIT;
        speed = speed_wide[6:0];

        // A negative error turns forward; the reverse bit swaps the sense.
        forward = neg7_reg ^ cfg.reverse_direction;
        if (speed == 7'd0)
            sspeed = 8'sd0;
        else if (forward)
            sspeed = $signed({1'b0, speed});
        else
            sspeed = -$signed({1'b0, speed});

        drive_wide = $signed({2'b00, cfg.drive_center}) + $signed({{2{sspeed[7]}}, sspeed});
        if (drive_wide < 0)
            drive = 8'd0;
        else if (drive_wide > $signed({2'b00, sasc_pkg::DRIVE_LIMIT}))
            drive = sasc_pkg::DRIVE_LIMIT;
        else
            drive = drive_wide[7:0];

        result.drive    = drive;
        result.sspeed   = sspeed;
        result.at_rest  = (speed == 7'd0);
        result.position = pos7_reg;
    end

endmodule

`default_nettype wire
